// ===== rtl/byte_stream_reassembler_defines.svh =====
// Assertion macros for the byte stream reassembler.
`ifndef BYTE_STREAM_REASSEMBLER_DEFINES_SVH
`define BYTE_STREAM_REASSEMBLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BSR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsr assertion failed");
`define BSR_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) else $error("bsr assertion failed");
`else
`define BSR_ASSERT(name, clk, rst_n, prop)
`define BSR_ASSERT_NR(name, clk, prop)
`endif

`endif

// ===== rtl/bsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int WIN_W        = 11;
    localparam int IDX_W        = 64;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 96;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [1:0] {
        RSEL_READ,
        RSEL_WALK,
        RSEL_STORE
    } rsel_t;

    typedef struct packed {
        logic  clr_step;
        logic  mem_re;
        rsel_t rsel;
        logic  wchk;
        logic  waddr;
        logic  wr_store;
        logic  wr_walk;
        logic  rd_take;
        logic  load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic slot_valid;
        logic unread_nz;
        logic free_nz;
        logic out_busy;
    } ctrl_stat_t;

endpackage
`default_nettype wire

// ===== rtl/bsr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic [1:0]         in_command,
    output logic                    s_tready,
    output bsr_pkg::ctrl_cmd_t      cmd,
    input  wire bsr_pkg::ctrl_stat_t stat
);
    import bsr_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WCHK,
        S_WADDR,
        S_WRD,
        S_WUPD,
        S_RCHK,
        S_RDATA,
        S_WALK,
        S_WTEST,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rsel   = RSEL_READ;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    case (in_command)
                        CMD_WRITE: state_next = S_WCHK;
                        CMD_READ:  state_next = S_RCHK;
                        default:   state_next = S_WALK;
                    endcase
                end
            end
            S_WCHK: begin
                cmd.wchk   = 1'b1;
                state_next = S_WADDR;
            end
            S_WADDR: begin
                cmd.waddr  = 1'b1;
                state_next = stat.in_range ? S_WRD : S_WALK;
            end
            S_WRD: begin
                cmd.mem_re = 1'b1;
                cmd.rsel   = RSEL_STORE;
                state_next = S_WUPD;
            end
            S_WUPD: begin
                cmd.wr_store = !stat.slot_valid;
                state_next   = S_WALK;
            end
            S_RCHK: begin
                cmd.mem_re = stat.unread_nz;
                cmd.rsel   = RSEL_READ;
                state_next = stat.unread_nz ? S_RDATA : S_WALK;
            end
            S_RDATA: begin
                cmd.rd_take = 1'b1;
                state_next  = S_WALK;
            end
            S_WALK: begin
                cmd.mem_re = stat.free_nz;
                cmd.rsel   = RSEL_WALK;
                state_next = stat.free_nz ? S_WTEST : S_DONE;
            end
            S_WTEST: begin
                cmd.wr_walk = stat.slot_valid;
                state_next  = stat.slot_valid ? S_WALK : S_DONE;
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/bsr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_reassembler_defines.svh"
module bsr_datapath #(
    parameter int CAPACITY = bsr_pkg::DEF_CAPACITY
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [bsr_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bsr_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    input  wire logic                           cfg_valid,
    input  wire logic [bsr_pkg::WIN_W-1:0]      cfg_data,
    input  wire bsr_pkg::ctrl_cmd_t             cmd,
    output bsr_pkg::ctrl_stat_t                 stat
);
    import bsr_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [8:0]        mem [CAPACITY];
    logic [8:0]        rdata_reg;
    logic [AW-1:0]     clr_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [7:0]        byte_reg;
    logic [IDX_W-1:0]  rd_reg, asm_reg, end_pos_reg;
    logic [AW-1:0]     rd_slot_reg, asm_slot_reg, store_slot_reg;
    logic [CW-1:0]     pending_reg, off_reg;
    logic              in_range_reg, end_seen_reg, closed_reg;
    logic              got_valid_reg;
    logic [7:0]        got_byte_reg;
    logic              m_tvalid_reg, m_tuser_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic              accept;
    logic [CW-1:0]     wsize, unread, free;
    logic [IDX_W-1:0]  diff;
    logic [AW:0]       slot_sum;
    logic [AW-1:0]     store_slot;
    logic              mem_we;
    logic [AW-1:0]     waddr, raddr;
    logic [8:0]        wdata;
    logic              closed_next;
    logic [31:0]       pend32, unread32;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        if (32'(win_reg) > CAPACITY) wsize = CW'(CAPACITY);
        else wsize = CW'(win_reg);
        unread = asm_reg[CW-1:0] - rd_reg[CW-1:0];
        free   = (unread >= wsize) ? '0 : wsize - unread;
        diff   = idx_reg - asm_reg;
        slot_sum = (AW+1)'(asm_slot_reg) + (AW+1)'(off_reg);
        if (slot_sum >= (AW+1)'(CAPACITY)) slot_sum = slot_sum - (AW+1)'(CAPACITY);
        store_slot = slot_sum[AW-1:0];
    end

    always_comb begin
        mem_we = 1'b0;
        waddr  = clr_reg;
        wdata  = '0;
        if (cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (cmd.wr_store) begin
            mem_we = 1'b1;
            waddr  = store_slot_reg;
            wdata  = {1'b1, byte_reg};
        end else if (cmd.wr_walk) begin
            mem_we = 1'b1;
            waddr  = asm_slot_reg;
            wdata  = {1'b0, rdata_reg[7:0]};
        end
        case (cmd.rsel)
            RSEL_WALK:  raddr = asm_slot_reg;
            RSEL_STORE: raddr = store_slot_reg;
            default:    raddr = rd_slot_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr] <= wdata;
        if (cmd.mem_re) rdata_reg <= mem[raddr];
    end

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == AW'(CAPACITY - 1)) ? '0 : s + 1'b1;
    endfunction

    assign closed_next = closed_reg || (end_seen_reg && (asm_reg >= end_pos_reg));
    assign pend32      = 32'(pending_reg);
    assign unread32    = 32'(unread);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            win_reg       <= WIN_W'(1024);
            rd_reg        <= '0;
            asm_reg       <= '0;
            rd_slot_reg   <= '0;
            asm_slot_reg  <= '0;
            pending_reg   <= '0;
            end_seen_reg  <= 1'b0;
            end_pos_reg   <= '0;
            closed_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) win_reg <= cfg_data;
            if (cmd.clr_step) clr_reg <= clr_reg + 1'b1;
            if (accept) begin
                if (s_tuser == CMD_END) begin
                    end_seen_reg <= 1'b1;
                    end_pos_reg  <= s_tdata[IDX_W-1:0];
                end else if (s_tuser == CMD_WRITE && s_tlast) begin
                    end_seen_reg <= 1'b1;
                    end_pos_reg  <= s_tdata[IDX_W-1:0] + 64'd1;
                end
            end
            if (cmd.wr_store) pending_reg <= pending_reg + 1'b1;
            if (cmd.wr_walk) begin
                if (pending_reg != '0) pending_reg <= pending_reg - 1'b1;
                asm_reg      <= asm_reg + 64'd1;
                asm_slot_reg <= slot_inc(asm_slot_reg);
            end
            if (cmd.rd_take) begin
                rd_reg      <= rd_reg + 64'd1;
                rd_slot_reg <= slot_inc(rd_slot_reg);
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
                closed_reg   <= closed_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg       <= s_tdata[IDX_W-1:0];
            byte_reg      <= s_tdata[IN_DATA_W-1:IDX_W];
            got_valid_reg <= 1'b0;
            got_byte_reg  <= '0;
        end
        if (cmd.wchk) begin
            in_range_reg <= (idx_reg >= asm_reg) && (diff < 64'(free));
            off_reg      <= diff[CW-1:0];
        end
        if (cmd.waddr) store_slot_reg <= store_slot;
        if (cmd.rd_take) begin
            got_valid_reg <= 1'b1;
            got_byte_reg  <= rdata_reg[7:0];
        end
        if (cmd.load_out) begin
            m_tuser_reg <= got_valid_reg;
            m_tdata_reg <= {1'b0, asm_reg, unread32[10:0], pend32[10:0],
                            closed_next, got_byte_reg};
        end
    end

    always_comb begin
        stat.clr_last   = (clr_reg == AW'(CAPACITY - 1));
        stat.in_range   = in_range_reg;
        stat.slot_valid = rdata_reg[8];
        stat.unread_nz  = (unread != '0);
        stat.free_nz    = (free != '0);
        stat.out_busy   = m_tvalid_reg && !m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `BSR_ASSERT(a_slots_bounded, aclk, aresetn, (32'(pending_reg) + 32'(unread) <= CAPACITY))
    `BSR_ASSERT(a_rd_step, aclk, aresetn, (rd_reg != $past(rd_reg) |-> rd_reg == $past(rd_reg) + 64'd1))
    `BSR_ASSERT(a_asm_step, aclk, aresetn, (asm_reg != $past(asm_reg) |-> asm_reg == $past(asm_reg) + 64'd1))

endmodule
`default_nettype wire

// ===== rtl/byte_stream_reassembler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Reassembles an out-of-order byte stream into a ring of CAPACITY slots that also
// buffers the assembled output; one result beat per command beat. After reset a
// clearing pass writes every slot before the first beat is taken. An end mark or
// other command goes straight to the run walk; a read takes the oldest unread byte
// if there is one; a write checks the index against the window, then stores the
// byte in its slot if that slot is empty (an out-of-window byte is dropped). The
// run walk then assembles bytes until a slot is empty or the window is full, and
// the result beat waits while m_tready holds back a previous one; the ring memory
// is read and written in separate states for each walked slot.
module byte_stream_reassembler #(
    parameter int CAPACITY = bsr_pkg::DEF_CAPACITY
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bsr_pkg::IN_DATA_W-1:0]  s_tdata,   // stream_index, data_byte
    input  wire logic [1:0]                     s_tuser,   // command
    input  wire logic                           s_tlast,   // final_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bsr_pkg::OUT_DATA_W-1:0]      m_tdata,   // read_byte, stream_closed,
                                                           // bytes_pending, bytes_unread,
                                                           // next_expected, pad
    output logic                                m_tuser,   // read_valid
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bsr_pkg::WIN_W-1:0]      cfg_data   // window_bytes
);
    import bsr_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    bsr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .in_command (s_tuser),
        .s_tready   (s_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    bsr_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire
